/* src/nfps_pkg.sv */
// Shared widths, register index codes and the cell control bundle for the
// nearest four point selector. No dependencies.
`default_nettype none

package nfps_pkg;

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = 25;
    localparam int SQ_W        = 48;
    localparam int DIST_W      = 50;
    localparam int PIDX_W      = 16;
    localparam int RANK_W      = 2;
    localparam int AXES        = 3;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z = 2'd2;

    typedef struct packed {
        logic ins;      // insert the distance into the sorted store
        logic load;     // copy the updated store into the output row, clear store
        logic shift;    // output row head taken, advance the row
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/nfps_dist.sv */
// Three-stage squared distance pipeline: coordinate differences, squares, sum.
// Depends on nfps_pkg.
`default_nettype none

module nfps_dist #(
    parameter int IDX_W = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     enable,
    input  logic                                     in_valid,
    input  logic signed [nfps_pkg::COORD_W-1:0]      point [nfps_pkg::AXES],
    input  logic signed [nfps_pkg::COORD_W-1:0]      query [nfps_pkg::AXES],
    input  logic        [IDX_W-1:0]                  in_idx,
    input  logic                                     in_end,
    output logic                                     out_valid,
    output logic        [nfps_pkg::DIST_W-1:0]       out_dist,
    output logic        [IDX_W-1:0]                  out_idx,
    output logic                                     out_end
);

    logic                                 s1_valid_reg;
    logic                                 s2_valid_reg;
    logic                                 s3_valid_reg;
    logic signed [nfps_pkg::DIFF_W-1:0]   diff_reg [nfps_pkg::AXES];
    logic signed [nfps_pkg::DIFF_W-1:0]   diff_next [nfps_pkg::AXES];
    logic signed [2*nfps_pkg::DIFF_W-1:0] prod [nfps_pkg::AXES];
    logic        [nfps_pkg::SQ_W-1:0]     sq_reg [nfps_pkg::AXES];
    logic        [nfps_pkg::SQ_W-1:0]     sq_next [nfps_pkg::AXES];
    logic        [nfps_pkg::DIST_W-1:0]   dist_reg;
    logic        [nfps_pkg::DIST_W-1:0]   dist_next;
    logic        [IDX_W-1:0]              s1_idx_reg;
    logic        [IDX_W-1:0]              s2_idx_reg;
    logic        [IDX_W-1:0]              s3_idx_reg;
    logic                                 s1_end_reg;
    logic                                 s2_end_reg;
    logic                                 s3_end_reg;

    always_comb
    begin
        for (int k = 0; k < nfps_pkg::AXES; k++)
        begin
            diff_next[k] = nfps_pkg::DIFF_W'(point[k]) - nfps_pkg::DIFF_W'(query[k]);
            prod[k]      = diff_reg[k] * diff_reg[k];
            // square never exceeds (2^24-1)^2, so the low bits hold it
            sq_next[k]   = prod[k][nfps_pkg::SQ_W-1:0];
        end
        dist_next = nfps_pkg::DIST_W'(sq_reg[0]) + nfps_pkg::DIST_W'(sq_reg[1])
                  + nfps_pkg::DIST_W'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            diff_reg   <= diff_next;
            sq_reg     <= sq_next;
            dist_reg   <= dist_next;
            s1_idx_reg <= in_idx;
            s2_idx_reg <= s1_idx_reg;
            s3_idx_reg <= s2_idx_reg;
            s1_end_reg <= in_end;
            s2_end_reg <= s1_end_reg;
            s3_end_reg <= s2_end_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_dist  = dist_reg;
    assign out_idx   = s3_idx_reg;
    assign out_end   = s3_end_reg;

endmodule

`default_nettype wire

/* src/nfps_cell.sv */
// One slot of the sorted store plus one slot of the output unload row.
// Depends on nfps_pkg.
`default_nettype none

module nfps_cell #(
    parameter int IDX_W = 16,
    parameter int POS   = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nfps_pkg::cell_ctrl_t                ctrl,
    input  logic [nfps_pkg::DIST_W-1:0]         new_dist,
    input  logic [IDX_W-1:0]                    new_idx,
    input  logic                                prev_lt,
    input  logic                                prev_valid,
    input  logic [nfps_pkg::DIST_W-1:0]         prev_dist,
    input  logic [IDX_W-1:0]                    prev_idx,
    output logic                                lt,
    output logic                                kept_valid,
    output logic [nfps_pkg::DIST_W-1:0]         kept_dist,
    output logic [IDX_W-1:0]                    kept_idx,
    input  logic                                nxt_valid,
    input  logic [nfps_pkg::DIST_W-1:0]         nxt_dist,
    input  logic [IDX_W-1:0]                    nxt_idx,
    input  logic [nfps_pkg::RANK_W-1:0]         nxt_rank,
    output logic                                out_valid,
    output logic [nfps_pkg::DIST_W-1:0]         out_dist,
    output logic [IDX_W-1:0]                    out_idx,
    output logic [nfps_pkg::RANK_W-1:0]         out_rank
);

    localparam logic [nfps_pkg::RANK_W-1:0] RANK = nfps_pkg::RANK_W'(POS);

    logic                          valid_reg;
    logic                          valid_next;
    logic [nfps_pkg::DIST_W-1:0]   dist_reg;
    logic [nfps_pkg::DIST_W-1:0]   dist_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic                          out_valid_reg;
    logic [nfps_pkg::DIST_W-1:0]   out_dist_reg;
    logic [IDX_W-1:0]              out_idx_reg;
    logic [nfps_pkg::RANK_W-1:0]   out_rank_reg;

    always_comb
    begin
        // a tie puts the new point ahead of the kept one
        lt         = !valid_reg || (new_dist <= dist_reg);
        valid_next = valid_reg;
        dist_next  = dist_reg;
        idx_next   = idx_reg;
        if (prev_lt)
        begin
            valid_next = prev_valid;
            dist_next  = prev_dist;
            idx_next   = prev_idx;
        end
        else if (lt)
        begin
            valid_next = 1'b1;
            dist_next  = new_dist;
            idx_next   = new_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.ins)
            begin
                valid_reg <= ctrl.load ? 1'b0 : valid_next;
            end
            if (ctrl.load)
            begin
                out_valid_reg <= valid_next;
            end
            else if (ctrl.shift)
            begin
                out_valid_reg <= nxt_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            dist_reg <= dist_next;
            idx_reg  <= idx_next;
        end
        if (ctrl.load)
        begin
            out_dist_reg <= dist_next;
            out_idx_reg  <= idx_next;
            out_rank_reg <= RANK;
        end
        else if (ctrl.shift)
        begin
            out_dist_reg <= nxt_dist;
            out_idx_reg  <= nxt_idx;
            out_rank_reg <= nxt_rank;
        end
    end

    assign kept_valid = valid_reg;
    assign kept_dist  = dist_reg;
    assign kept_idx   = idx_reg;
    assign out_valid  = out_valid_reg;
    assign out_dist   = out_dist_reg;
    assign out_idx    = out_idx_reg;
    assign out_rank   = out_rank_reg;

endmodule

`default_nettype wire

/* src/nearest_four_point_select.sv */
// A run's results reach m_axis after its last point is accepted, through the three distance
// stages, the last one feeding the output row, then one per cycle while m_axis_tready is high.
// Throughput: one point per cycle; a last point waits at the insert stage while two
// or more results of the previous run remain, or the one left is not taken.
// Reset clears the query registers, the store and the output row at once.
// Depends on nfps_pkg, nfps_dist, nfps_cell.
`default_nettype none

module nearest_four_point_select #(
    parameter int KEEP_COUNT = 4,
    parameter int INDEX_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x[23:0], point_y[47:24], point_z[71:48], point_index[87:72]
    input  logic [nfps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,   // list_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // nearest_index[15:0], nearest_distance_sq[65:16], rank[67:66], zero[71:68]
    output logic [nfps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,   // last_of_run
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nfps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nfps_pkg::COORD_W-1:0]        cfg_data
);

    logic signed [nfps_pkg::COORD_W-1:0] query_reg [nfps_pkg::AXES];
    logic signed [nfps_pkg::COORD_W-1:0] point [nfps_pkg::AXES];

    logic                          advance;
    logic                          load_ok;
    logic                          d_valid;
    logic [nfps_pkg::DIST_W-1:0]   d_dist;
    logic [INDEX_BITS-1:0]         d_idx;
    logic                          d_end;
    nfps_pkg::cell_ctrl_t          ctrl;

    // store chain: entry [i] feeds cell i, cell i drives entry [i+1]
    logic [KEEP_COUNT:0]           lt_c;
    logic [KEEP_COUNT:0]           kv_c;
    logic [nfps_pkg::DIST_W-1:0]   kd_c [KEEP_COUNT+1];
    logic [INDEX_BITS-1:0]         ki_c [KEEP_COUNT+1];

    // output row: cell i drives entry [i], entry [KEEP_COUNT] is the empty tail
    logic [KEEP_COUNT:0]           ov;
    logic [nfps_pkg::DIST_W-1:0]   od [KEEP_COUNT+1];
    logic [INDEX_BITS-1:0]         oi [KEEP_COUNT+1];
    logic [nfps_pkg::RANK_W-1:0]   orank [KEEP_COUNT+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < nfps_pkg::AXES; k++)
            begin
                query_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                nfps_pkg::CFG_QUERY_X: query_reg[0] <= cfg_data;
                nfps_pkg::CFG_QUERY_Y: query_reg[1] <= cfg_data;
                nfps_pkg::CFG_QUERY_Z: query_reg[2] <= cfg_data;
                default: ;  // unknown register, drop
            endcase
        end
    end

    assign point[0] = s_axis_tdata[23:0];
    assign point[1] = s_axis_tdata[47:24];
    assign point[2] = s_axis_tdata[71:48];

    nfps_dist #(
        .IDX_W (INDEX_BITS)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (advance),
        .in_valid  (s_axis_tvalid),
        .point     (point),
        .query     (query_reg),
        .in_idx    (INDEX_BITS'(s_axis_tdata[87:72])),
        .in_end    (s_axis_tlast),
        .out_valid (d_valid),
        .out_dist  (d_dist),
        .out_idx   (d_idx),
        .out_end   (d_end)
    );

    // a run may unload only once the row holds at most its head, leaving now
    assign load_ok       = !ov[1] && (!ov[0] || m_axis_tready);
    assign advance       = !(d_valid && d_end && !load_ok);
    assign s_axis_tready = advance;

    assign ctrl.ins   = d_valid && advance;
    assign ctrl.load  = d_valid && advance && d_end;
    assign ctrl.shift = ov[0] && m_axis_tready;

    assign lt_c[0] = 1'b0;
    assign kv_c[0] = 1'b0;
    assign kd_c[0] = '0;
    assign ki_c[0] = '0;

    assign ov[KEEP_COUNT]    = 1'b0;
    assign od[KEEP_COUNT]    = '0;
    assign oi[KEEP_COUNT]    = '0;
    assign orank[KEEP_COUNT] = '0;

    for (genvar i = 0; i < KEEP_COUNT; i++)
    begin : g_cell
        nfps_cell #(
            .IDX_W (INDEX_BITS),
            .POS   (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_dist   (d_dist),
            .new_idx    (d_idx),
            .prev_lt    (lt_c[i]),
            .prev_valid (kv_c[i]),
            .prev_dist  (kd_c[i]),
            .prev_idx   (ki_c[i]),
            .lt         (lt_c[i+1]),
            .kept_valid (kv_c[i+1]),
            .kept_dist  (kd_c[i+1]),
            .kept_idx   (ki_c[i+1]),
            .nxt_valid  (ov[i+1]),
            .nxt_dist   (od[i+1]),
            .nxt_idx    (oi[i+1]),
            .nxt_rank   (orank[i+1]),
            .out_valid  (ov[i]),
            .out_dist   (od[i]),
            .out_idx    (oi[i]),
            .out_rank   (orank[i])
        );
    end

    assign m_axis_tvalid = ov[0];
    assign m_axis_tlast  = ov[0] && !ov[1];
    assign m_axis_tdata  = {4'b0000, orank[0], od[0], nfps_pkg::PIDX_W'(oi[0])};

endmodule

`default_nettype wire
